[rtl/core/rcr_pkg.sv]
// ----------------------------------------------------------------------------
// rcr_pkg
// Shared types, constants and tables for the report checksum and key resync
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package rcr_pkg;

   localparam int KEY_LEN       = 8;
   localparam int KEY_IDX_W     = $clog2(KEY_LEN);
   localparam int SUM_BYTES     = 13;
   localparam int REPORT_LEN    = 14;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] SUM_SEED          = 8'h21;
   localparam logic [7:0] RETRY_LIMIT_RESET = 8'd3;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_RETRY_LIMIT = '0;

   // status codes
   localparam logic [1:0] STATUS_VALID  = 2'd0;
   localparam logic [1:0] STATUS_FAILED = 2'd1;
   localparam logic [1:0] STATUS_SHORT  = 2'd2;

   // request kinds and result kinds
   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_OPEN   = 1'b1;
   localparam logic OUT_STATUS  = 1'b0;
   localparam logic OUT_KEY     = 1'b1;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_XOR = 2'd2
   } op_type;

   // work handed from front to back
   typedef enum logic [1:0] {
      CMD_STATUS = 2'd0,   // status result only
      CMD_KEY    = 2'd1,   // key bytes, last one ends the run
      CMD_RESEND = 2'd2    // key bytes, then a status result
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [1:0]   status;
   } cmd_type;

   function automatic op_type sum_op(input logic [3:0] pos);
      op_type op;
      case (pos) inside
         4'd0, 4'd4, 4'd5, 4'd8, 4'd9: op = OP_ADD;
         4'd1, 4'd2, 4'd10, 4'd11:     op = OP_SUB;
         default:                      op = OP_XOR;
      endcase
      return op;
   endfunction

   function automatic logic [7:0] key_at(input logic [KEY_IDX_W-1:0] idx);
      logic [7:0] k;
      unique case (idx)
         3'd0:    k = 8'h01;
         3'd1:    k = 8'h12;
         3'd2:    k = 8'h6F;
         3'd3:    k = 8'h32;
         3'd4:    k = 8'h24;
         3'd5:    k = 8'h60;
         3'd6:    k = 8'h17;
         default: k = 8'h21;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

[rtl/core/rcr_req_if.sv]
// ----------------------------------------------------------------------------
// rcr_req_if
// Request channel: one report byte or an open command per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcr_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output kind, output data_byte, output last, input ready);
   modport sink   (input valid, input kind, input data_byte, input last, output ready);
endinterface

`default_nettype wire

[rtl/core/rcr_rsp_if.sv]
// ----------------------------------------------------------------------------
// rcr_rsp_if
// Response channel: a report status or one key byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcr_rsp_if;
   logic       valid;
   logic       ready;
   logic       out_kind;
   logic [1:0] status;
   logic [7:0] key_byte;
   logic       end_of_run;

   modport source (output valid, output out_kind, output status, output key_byte,
                   output end_of_run, input ready);
   modport sink   (input valid, input out_kind, input status, input key_byte,
                   input end_of_run, output ready);
endinterface

`default_nettype wire

[rtl/core/rcr_front.sv]
// ----------------------------------------------------------------------------
// rcr_front
// Accepts requests, runs the report checksum and failure count, and queues
// the work each request causes.
// ----------------------------------------------------------------------------
`default_nettype none

module rcr_front (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [7:0]     retry_limit,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire logic           req_kind,
   input  wire logic [7:0]     req_data_byte,
   input  wire logic           req_last,
   output logic                push,
   output rcr_pkg::cmd_type    push_cmd,
   input  wire logic           queue_full
);
   import rcr_pkg::*;

   logic [7:0] running_sum_ff,   running_sum_in;
   logic [3:0] byte_position_ff, byte_position_in;
   logic       sum_matched_ff,   sum_matched_in;
   logic [7:0] failure_count_ff, failure_count_in;

   logic       accept;
   logic [7:0] fail_inc;
   logic [7:0] sum_upd;
   logic [3:0] pos_upd;
   logic       matched_upd;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign fail_inc  = failure_count_ff + 8'd1;

   always_comb begin
      sum_upd     = running_sum_ff;
      pos_upd     = byte_position_ff;
      matched_upd = sum_matched_ff;
      if (byte_position_ff < 4'(SUM_BYTES)) begin
         case (sum_op(byte_position_ff))
            OP_ADD:  sum_upd = running_sum_ff + req_data_byte;
            OP_SUB:  sum_upd = running_sum_ff - req_data_byte;
            default: sum_upd = running_sum_ff ^ req_data_byte;
         endcase
         pos_upd = byte_position_ff + 4'd1;
      end else if (byte_position_ff == 4'(SUM_BYTES)) begin
         matched_upd = (running_sum_ff == req_data_byte);
         pos_upd     = byte_position_ff + 4'd1;
      end
   end

   always_comb begin
      running_sum_in   = running_sum_ff;
      byte_position_in = byte_position_ff;
      sum_matched_in   = sum_matched_ff;
      failure_count_in = failure_count_ff;
      push             = 1'b0;
      push_cmd.kind    = CMD_STATUS;
      push_cmd.status  = STATUS_VALID;
      if (accept) begin
         if (req_kind == KIND_OPEN) begin
            failure_count_in = '0;
            push             = 1'b1;
            push_cmd.kind    = CMD_KEY;
         end else if (!req_last) begin
            running_sum_in   = sum_upd;
            byte_position_in = pos_upd;
            sum_matched_in   = matched_upd;
         end else begin
            push             = 1'b1;
            // drop the report once its status is known
            running_sum_in   = SUM_SEED;
            byte_position_in = '0;
            sum_matched_in   = 1'b0;
            if (pos_upd < 4'(REPORT_LEN)) begin
               push_cmd.status = STATUS_SHORT;
            end else if (matched_upd) begin
               failure_count_in = '0;
            end else begin
               push_cmd.status = STATUS_FAILED;
               if (fail_inc >= retry_limit) begin
                  failure_count_in = '0;
                  push_cmd.kind    = CMD_RESEND;
               end else begin
                  failure_count_in = fail_inc;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff   <= SUM_SEED;
         byte_position_ff <= '0;
         sum_matched_ff   <= 1'b0;
         failure_count_ff <= '0;
      end else begin
         running_sum_ff   <= running_sum_in;
         byte_position_ff <= byte_position_in;
         sum_matched_ff   <= sum_matched_in;
         failure_count_ff <= failure_count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/rcr_queue.sv]
// ----------------------------------------------------------------------------
// rcr_queue
// Short FIFO of pending work between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rcr_queue #(
   parameter int DEPTH = rcr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  rcr_pkg::cmd_type push_cmd,
   output logic             full,
   input  wire logic        pop,
   output rcr_pkg::cmd_type head_cmd,
   output logic             empty
);
   import rcr_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entries_ff [DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/rcr_back.sv]
// ----------------------------------------------------------------------------
// rcr_back
// Expands queued work into response items: key bytes and report status,
// through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rcr_back (
   input  wire logic        clock,
   input  wire logic        reset,
   input  rcr_pkg::cmd_type head_cmd,
   input  wire logic        queue_empty,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_out_kind,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_key_byte,
   output logic             rsp_end_of_run
);
   import rcr_pkg::*;

   logic                 rsp_valid_ff;
   logic                 out_kind_ff;
   logic [1:0]           status_ff;
   logic [7:0]           key_byte_ff;
   logic                 end_of_run_ff;
   logic [KEY_IDX_W-1:0] key_idx_ff,      key_idx_in;
   logic                 status_phase_ff, status_phase_in;

   logic                 load, advance, last_key;
   logic                 gen_kind, gen_end;
   logic [1:0]           gen_status;
   logic [7:0]           gen_key;
   logic                 gen_pop;

   assign load     = !rsp_valid_ff || rsp_ready;
   assign advance  = load && !queue_empty;
   assign last_key = (key_idx_ff == KEY_IDX_W'(KEY_LEN - 1));
   assign pop      = advance && gen_pop;

   always_comb begin
      gen_kind   = OUT_STATUS;
      gen_status = head_cmd.status;
      gen_key    = '0;
      gen_end    = 1'b1;
      gen_pop    = 1'b1;
      unique case (head_cmd.kind)
         CMD_KEY: begin
            gen_kind   = OUT_KEY;
            gen_status = STATUS_VALID;
            gen_key    = key_at(key_idx_ff);
            gen_end    = last_key;
            gen_pop    = last_key;
         end
         CMD_RESEND: begin
            if (!status_phase_ff) begin
               gen_kind   = OUT_KEY;
               gen_status = STATUS_VALID;
               gen_key    = key_at(key_idx_ff);
               gen_end    = 1'b0;
               gen_pop    = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      key_idx_in      = key_idx_ff;
      status_phase_in = status_phase_ff;
      if (advance) begin
         if (gen_kind == OUT_KEY) begin
            key_idx_in = last_key ? '0 : key_idx_ff + 1'b1;
            // resend: status follows the eighth key byte
            if (head_cmd.kind == CMD_RESEND && last_key) begin
               status_phase_in = 1'b1;
            end
         end
         if (gen_pop) begin
            status_phase_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         key_idx_ff      <= '0;
         status_phase_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= !queue_empty;
         end
         key_idx_ff      <= key_idx_in;
         status_phase_ff <= status_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_kind_ff   <= gen_kind;
         status_ff     <= gen_status;
         key_byte_ff   <= gen_key;
         end_of_run_ff <= gen_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_kind   = out_kind_ff;
   assign rsp_status     = status_ff;
   assign rsp_key_byte   = key_byte_ff;
   assign rsp_end_of_run = end_of_run_ff;

endmodule

`default_nettype wire

[rtl/core/report_checksum_resync.sv]
// A status or the first key byte passes the work queue, then the registered output stage
//   of the back end, before it is presented on rsp.
// One report byte per cycle while the queue has room; an open command yields 8 key bytes,
//   a failure at the retry limit 8 and a status, via the single-item output stage.
// The work queue (QUEUE_DEPTH, 4 entries by default) stalls req only when the back end falls behind.
// Reset (synchronous): checksum restarts at seed 0x21, count cleared, retry_limit = 3,
//   queue and output stage emptied; no clearing pass.
// ----------------------------------------------------------------------------
// report_checksum_resync
// Report checksum checker with failure counting and session key resend.
// ----------------------------------------------------------------------------
`default_nettype none

module report_checksum_resync #(
   parameter int QUEUE_DEPTH = rcr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rcr_req_if.sink                             req_ch,
   rcr_rsp_if.source                           rsp_ch,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [rcr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [rcr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [rcr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);
   import rcr_pkg::*;

   logic [7:0] retry_limit_ff;
   logic       reg_hit;
   logic       csr_write;

   logic       push, queue_full, queue_empty, pop;
   cmd_type    push_cmd, head_cmd;

   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_RETRY_LIMIT);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && reg_hit;
   assign csr_prdata = reg_hit ? CSR_DATA_W'(retry_limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= RETRY_LIMIT_RESET;
      end else if (csr_write) begin
         retry_limit_ff <= csr_pwdata[7:0];
      end
   end

   rcr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .retry_limit   (retry_limit_ff),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_kind      (req_ch.kind),
      .req_data_byte (req_ch.data_byte),
      .req_last      (req_ch.last),
      .push          (push),
      .push_cmd      (push_cmd),
      .queue_full    (queue_full)
   );

   rcr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty)
   );

   rcr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_cmd       (head_cmd),
      .queue_empty    (queue_empty),
      .pop            (pop),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_out_kind   (rsp_ch.out_kind),
      .rsp_status     (rsp_ch.status),
      .rsp_key_byte   (rsp_ch.key_byte),
      .rsp_end_of_run (rsp_ch.end_of_run)
   );

endmodule

`default_nettype wire

[rtl/core/rcr_checker.sv]
// ----------------------------------------------------------------------------
// rcr_checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rcr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_out_kind,
   input wire logic [1:0] rsp_status,
   input wire logic [7:0] rsp_key_byte,
   input wire logic       rsp_end_of_run
);
   import rcr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_key_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == OUT_KEY |-> rsp_status == STATUS_VALID)
      else $error("key byte carries a status");

   a_status_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == OUT_STATUS |-> rsp_end_of_run && rsp_key_byte == 8'd0)
      else $error("status result malformed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_VALID || rsp_status == STATUS_FAILED
                    || rsp_status == STATUS_SHORT)
      else $error("undefined status code");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind report_checksum_resync rcr_checker u_rcr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_out_kind   (rsp_ch.out_kind),
   .rsp_status     (rsp_ch.status),
   .rsp_key_byte   (rsp_ch.key_byte),
   .rsp_end_of_run (rsp_ch.end_of_run)
);

`default_nettype wire
